// File: sv/ctse_pkg.sv
// ----------------------------------------------------------------------------
// Calendar time set editor package
// Event kinds, field select codes, field limits and the day-of-month limit.
// ----------------------------------------------------------------------------
package ctse_pkg;

	typedef enum logic [2:0] {
		KIND_MODE   = 3'd0,
		KIND_SELECT = 3'd1,
		KIND_UP     = 3'd2,
		KIND_DOWN   = 3'd3,
		KIND_TICK   = 3'd4,
		KIND_READ   = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		FLD_YEAR   = 3'd0,
		FLD_MONTH  = 3'd1,
		FLD_DAY    = 3'd2,
		FLD_HOUR   = 3'd3,
		FLD_MINUTE = 3'd4,
		FLD_SECOND = 3'd5
	} field_t;

	localparam logic [2:0]  FIELD_LAST      = 3'd5;
	localparam logic [6:0]  YEAR_MAX        = 7'd99;
	localparam logic [3:0]  MONTH_MAX       = 4'd12;
	localparam logic [4:0]  HOUR_MAX        = 5'd23;
	localparam logic [5:0]  MIN_SEC_MAX     = 6'd59;
	localparam logic [15:0] BLINK_RESET_VAL = 16'd500;

	// Days in month; leap year every fourth year, unknown month gives 31
	function automatic logic [4:0] day_limit(input logic [1:0] yr_lsb, input logic [3:0] mo);
		logic [4:0] lim;
		case (mo)
			4'd4, 4'd6, 4'd9, 4'd11: lim = 5'd30;
			4'd2:                    lim = (yr_lsb == 2'd0) ? 5'd29 : 5'd28;
			default:                 lim = 5'd31;
		endcase
		return lim;
	endfunction

endpackage

// File: sv/calendar_time_set_editor_core.sv
// ----------------------------------------------------------------------------
// Calendar time set editor core
// A result is registered and presented in the cycle after its input transaction.
// Throughput: one transaction per cycle; the state registers double as the
// result register, so input is taken whenever the result slot is free or
// being emptied in the same cycle.
// Reset: arst_n clears time, mode, selection, blink state and the tick
// counter; the blink half period returns to 500.
// ----------------------------------------------------------------------------
module calendar_time_set_editor_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: blink half period
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	// input transactions
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  kind,
	input  logic [6:0]  load_year,
	input  logic [3:0]  load_month,
	input  logic [4:0]  load_day,
	input  logic [4:0]  load_hour,
	input  logic [5:0]  load_minute,
	input  logic [5:0]  load_second,
	// result transactions
	output logic        result_valid,
	input  logic        result_ready,
	output logic [6:0]  year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic        setting_active,
	output logic [2:0]  selected_field,
	output logic        blink_on,
	output logic        commit_time
);

	// Architectural state; its registers also drive the result outputs.
	logic [6:0]  year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic        edit_mode_q;
	logic [2:0]  field_sel_q;
	logic        blink_q;
	logic [15:0] tick_cnt_q;
	logic [15:0] blink_half_q;
	logic        commit_q;
	logic        result_valid_q;

	logic        accept;

	// Adjusted fields, signed so that decrement below zero is visible.
	logic signed [8:0] v_year, v_month, v_day, v_hour, v_minute, v_second;
	logic signed [8:0] delta;
	logic [4:0]        lim;
	logic signed [8:0] lim_s;

	logic [16:0] tick_next;
	logic        tick_wrap;
	logic        is_up;

	// Result slot is free, or its transaction leaves this cycle.
	assign item_ready = !result_valid_q || result_ready;
	assign accept     = item_valid && item_ready;

	assign is_up = (kind == ctse_pkg::KIND_UP);
	assign delta = is_up ? 9'sd1 : -9'sd1;

	// Up/down edit: step the selected field, then wrap every field.
	always_comb begin
		v_year   = $signed({2'b00, year_q});
		v_month  = $signed({5'b0, month_q});
		v_day    = $signed({4'b0, day_q});
		v_hour   = $signed({4'b0, hour_q});
		v_minute = $signed({3'b0, minute_q});
		v_second = $signed({3'b0, second_q});
		case (field_sel_q)
			ctse_pkg::FLD_YEAR:   v_year   = v_year + delta;
			ctse_pkg::FLD_MONTH:  v_month  = v_month + delta;
			ctse_pkg::FLD_DAY:    v_day    = v_day + delta;
			ctse_pkg::FLD_HOUR:   v_hour   = v_hour + delta;
			ctse_pkg::FLD_MINUTE: v_minute = v_minute + delta;
			ctse_pkg::FLD_SECOND: v_second = v_second + delta;
			default: ;
		endcase
		lim   = 5'd31;
		lim_s = 9'sd31;
		if (is_up) begin
			if (v_year > $signed({2'b00, ctse_pkg::YEAR_MAX}))  v_year  = 9'sd0;
			if (v_month > $signed({5'b0, ctse_pkg::MONTH_MAX})) v_month = 9'sd1;
			lim   = ctse_pkg::day_limit(v_year[1:0], v_month[3:0]);
			lim_s = $signed({4'b0, lim});
			if (v_day > lim_s) v_day = 9'sd1;
			if (v_hour > $signed({4'b0, ctse_pkg::HOUR_MAX}))      v_hour   = 9'sd0;
			if (v_minute > $signed({3'b0, ctse_pkg::MIN_SEC_MAX})) v_minute = 9'sd0;
			if (v_second > $signed({3'b0, ctse_pkg::MIN_SEC_MAX})) v_second = 9'sd0;
		end else begin
			if (v_year < 9'sd0)  v_year  = $signed({2'b00, ctse_pkg::YEAR_MAX});
			if (v_month < 9'sd1) v_month = $signed({5'b0, ctse_pkg::MONTH_MAX});
			lim   = ctse_pkg::day_limit(v_year[1:0], v_month[3:0]);
			lim_s = $signed({4'b0, lim});
			// a stored day of zero also lands on the month limit
			if (v_day < 9'sd1) v_day = lim_s;
			if (v_day > lim_s) v_day = 9'sd1;
			if (v_hour < 9'sd0)   v_hour   = $signed({4'b0, ctse_pkg::HOUR_MAX});
			if (v_minute < 9'sd0) v_minute = $signed({3'b0, ctse_pkg::MIN_SEC_MAX});
			if (v_second < 9'sd0) v_second = $signed({3'b0, ctse_pkg::MIN_SEC_MAX});
		end
	end

	// Blink divider: a period of zero or one toggles on every tick.
	assign tick_next = {1'b0, tick_cnt_q} + 17'd1;
	assign tick_wrap = (tick_next >= {1'b0, blink_half_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_half_q <= ctse_pkg::BLINK_RESET_VAL;
		end else if (cfg_wr_en) begin
			blink_half_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q         <= '0;
			month_q        <= '0;
			day_q          <= '0;
			hour_q         <= '0;
			minute_q       <= '0;
			second_q       <= '0;
			edit_mode_q    <= 1'b0;
			field_sel_q    <= '0;
			blink_q        <= 1'b0;
			tick_cnt_q     <= '0;
			commit_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (accept) begin
				// commit pulses only on the mode key that leaves set mode
				commit_q <= (kind == ctse_pkg::KIND_MODE) && edit_mode_q;
				case (kind)
					ctse_pkg::KIND_MODE: begin
						if (!edit_mode_q) begin
							edit_mode_q <= 1'b1;
							field_sel_q <= ctse_pkg::FLD_YEAR;
						end else begin
							edit_mode_q <= 1'b0;
						end
					end
					ctse_pkg::KIND_SELECT: begin
						if (edit_mode_q) begin
							field_sel_q <= (field_sel_q == ctse_pkg::FIELD_LAST) ?
								ctse_pkg::FLD_YEAR : field_sel_q + 3'd1;
						end
					end
					ctse_pkg::KIND_UP, ctse_pkg::KIND_DOWN: begin
						if (edit_mode_q) begin
							year_q   <= v_year[6:0];
							month_q  <= v_month[3:0];
							day_q    <= v_day[4:0];
							hour_q   <= v_hour[4:0];
							minute_q <= v_minute[5:0];
							second_q <= v_second[5:0];
						end
					end
					ctse_pkg::KIND_TICK: begin
						if (tick_wrap) begin
							tick_cnt_q <= '0;
							blink_q    <= !blink_q;
						end else begin
							tick_cnt_q <= tick_next[15:0];
						end
					end
					ctse_pkg::KIND_READ: begin
						// readings are dropped while the user is editing
						if (!edit_mode_q) begin
							year_q   <= load_year;
							month_q  <= load_month;
							day_q    <= load_day;
							hour_q   <= load_hour;
							minute_q <= load_minute;
							second_q <= load_second;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign result_valid   = result_valid_q;
	assign year           = year_q;
	assign month          = month_q;
	assign day            = day_q;
	assign hour           = hour_q;
	assign minute         = minute_q;
	assign second         = second_q;
	assign setting_active = edit_mode_q;
	assign selected_field = field_sel_q;
	assign blink_on       = blink_q;
	assign commit_time    = commit_q;

endmodule

// File: sv/ctse_checker.sv
// ----------------------------------------------------------------------------
// Calendar time set editor checker
// Port-level properties of the editor core, bound to the top level.
// ----------------------------------------------------------------------------
module ctse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [2:0]  selected_field,
	input logic        setting_active,
	input logic        commit_time,
	input logic [6:0]  year
);

	// every accepted transaction yields a result next cycle
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("accepted transaction produced no result");

	// commit only on leaving set mode
	a_commit_leaves_edit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && commit_time |-> !setting_active)
		else $error("commit while still in set mode");

	// selection stays within the six fields
	a_select_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (selected_field <= ctse_pkg::FIELD_LAST))
		else $error("selected field out of range");

	// stalled result holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(year)
			&& $stable(commit_time))
		else $error("stalled result changed");

endmodule

bind calendar_time_set_editor_core ctse_checker u_ctse_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_ready     (item_ready),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.selected_field (selected_field),
	.setting_active (setting_active),
	.commit_time    (commit_time),
	.year           (year)
);

// File: test/calendar_time_set_editor_core_tb.sv
// ----------------------------------------------------------------------------
// Calendar time set editor core testbench
// Sends key, tick and clock-reading transactions through the valid/ready
// input channel while a scoreboard class predicts the time, mode, selection,
// blink and commit view after each one. Results are checked in order, field
// by field. The blink half period is changed between phases, and the sender
// and receiver idle at random rates that differ from phase to phase.
// ----------------------------------------------------------------------------
typedef struct {
	logic [6:0] yr;
	logic [3:0] mon;
	logic [4:0] dom;
	logic [4:0] hr;
	logic [5:0] mins;
	logic [5:0] secs;
	logic       active;
	logic [2:0] sel;
	logic       blink;
	logic       commit;
} clock_view_t;

// Predicts the editor view after each accepted transaction and checks results
class time_editor_board;
	logic [6:0]  fld [6];
	logic        editing;
	logic [2:0]  sel;
	logic        blink;
	logic [15:0] ticks;
	logic [15:0] half_period;
	clock_view_t pending_views [$];
	int          mismatches;

	function new();
		foreach (fld[i])
			fld[i] = '0;
		editing     = 1'b0;
		sel         = ctse_pkg::FLD_YEAR;
		blink       = 1'b0;
		ticks       = '0;
		half_period = ctse_pkg::BLINK_RESET_VAL;
		mismatches  = 0;
	endfunction

	function void set_half_period(logic [15:0] p);
		half_period = p;
	endfunction

	function int month_days(int yr, int mo);
		case (mo)
			4, 6, 9, 11: return 30;
			2:           return (yr % 4 == 0) ? 29 : 28;
			default:     return 31;
		endcase
	endfunction

	// Up/down on the selected field, then wrap every field
	function void step_field(bit up);
		int v [6];
		int lim;
		foreach (v[i])
			v[i] = int'(fld[i]);
		v[sel] += up ? 1 : -1;
		if (up) begin
			if (v[ctse_pkg::FLD_YEAR] > ctse_pkg::YEAR_MAX) v[ctse_pkg::FLD_YEAR] = 0;
			if (v[ctse_pkg::FLD_MONTH] > ctse_pkg::MONTH_MAX) v[ctse_pkg::FLD_MONTH] = 1;
			lim = month_days(v[ctse_pkg::FLD_YEAR], v[ctse_pkg::FLD_MONTH]);
			if (v[ctse_pkg::FLD_DAY] > lim) v[ctse_pkg::FLD_DAY] = 1;
			if (v[ctse_pkg::FLD_HOUR] > ctse_pkg::HOUR_MAX) v[ctse_pkg::FLD_HOUR] = 0;
			if (v[ctse_pkg::FLD_MINUTE] > ctse_pkg::MIN_SEC_MAX) v[ctse_pkg::FLD_MINUTE] = 0;
			if (v[ctse_pkg::FLD_SECOND] > ctse_pkg::MIN_SEC_MAX) v[ctse_pkg::FLD_SECOND] = 0;
		end else begin
			// above-range fields other than the day stay as they are on a down key
			if (v[ctse_pkg::FLD_YEAR] < 0) v[ctse_pkg::FLD_YEAR] = ctse_pkg::YEAR_MAX;
			if (v[ctse_pkg::FLD_MONTH] < 1) v[ctse_pkg::FLD_MONTH] = ctse_pkg::MONTH_MAX;
			lim = month_days(v[ctse_pkg::FLD_YEAR], v[ctse_pkg::FLD_MONTH]);
			if (v[ctse_pkg::FLD_DAY] < 1) v[ctse_pkg::FLD_DAY] = lim;
			if (v[ctse_pkg::FLD_DAY] > lim) v[ctse_pkg::FLD_DAY] = 1;
			if (v[ctse_pkg::FLD_HOUR] < 0) v[ctse_pkg::FLD_HOUR] = ctse_pkg::HOUR_MAX;
			if (v[ctse_pkg::FLD_MINUTE] < 0) v[ctse_pkg::FLD_MINUTE] = ctse_pkg::MIN_SEC_MAX;
			if (v[ctse_pkg::FLD_SECOND] < 0) v[ctse_pkg::FLD_SECOND] = ctse_pkg::MIN_SEC_MAX;
		end
		foreach (fld[i])
			fld[i] = 7'(v[i]);
	endfunction

	function void note_event(logic [2:0] k, logic [6:0] ly, logic [3:0] lmo, logic [4:0] ld,
			logic [4:0] lh, logic [5:0] lmi, logic [5:0] ls);
		clock_view_t e;
		logic        commit;
		commit = 1'b0;
		case (k)
			ctse_pkg::KIND_MODE: begin
				if (!editing) begin
					editing = 1'b1;
					sel     = ctse_pkg::FLD_YEAR;
				end else begin
					editing = 1'b0;
					commit  = 1'b1;
				end
			end
			ctse_pkg::KIND_SELECT: begin
				if (editing)
					sel = (sel == ctse_pkg::FIELD_LAST) ?
						3'(ctse_pkg::FLD_YEAR) : sel + 3'd1;
			end
			ctse_pkg::KIND_UP, ctse_pkg::KIND_DOWN: begin
				if (editing)
					step_field(k == ctse_pkg::KIND_UP);
			end
			ctse_pkg::KIND_TICK: begin
				// zero period toggles on every tick
				if ({16'd0, ticks} + 32'd1 >= {16'd0, half_period}) begin
					ticks = '0;
					blink = ~blink;
				end else begin
					ticks = ticks + 16'd1;
				end
			end
			ctse_pkg::KIND_READ: begin
				// readings are stored unchecked, but only outside set mode
				if (!editing) begin
					fld[ctse_pkg::FLD_YEAR]   = ly;
					fld[ctse_pkg::FLD_MONTH]  = 7'(lmo);
					fld[ctse_pkg::FLD_DAY]    = 7'(ld);
					fld[ctse_pkg::FLD_HOUR]   = 7'(lh);
					fld[ctse_pkg::FLD_MINUTE] = 7'(lmi);
					fld[ctse_pkg::FLD_SECOND] = 7'(ls);
				end
			end
			default: ;
		endcase
		e.yr     = fld[ctse_pkg::FLD_YEAR];
		e.mon    = fld[ctse_pkg::FLD_MONTH][3:0];
		e.dom    = fld[ctse_pkg::FLD_DAY][4:0];
		e.hr     = fld[ctse_pkg::FLD_HOUR][4:0];
		e.mins   = fld[ctse_pkg::FLD_MINUTE][5:0];
		e.secs   = fld[ctse_pkg::FLD_SECOND][5:0];
		e.active = editing;
		e.sel    = sel;
		e.blink  = blink;
		e.commit = commit;
		pending_views.push_back(e);
	endfunction

	task report_mismatch(string msg);
		mismatches++;
		$display("MISMATCH: %s", msg);
	endtask

	task cmp(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task check_view(clock_view_t got);
		clock_view_t want;
		if (pending_views.size() == 0) begin
			report_mismatch("result with no transaction pending");
		end else begin
			want = pending_views.pop_front();
			cmp("year", got.yr, want.yr);
			cmp("month", got.mon, want.mon);
			cmp("day", got.dom, want.dom);
			cmp("hour", got.hr, want.hr);
			cmp("minute", got.mins, want.mins);
			cmp("second", got.secs, want.secs);
			cmp("setting_active", got.active, want.active);
			cmp("selected_field", got.sel, want.sel);
			cmp("blink_on", got.blink, want.blink);
			cmp("commit_time", got.commit, want.commit);
		end
	endtask
endclass

module calendar_time_set_editor_core_tb;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 190;

	typedef struct {
		logic [6:0] yr;
		logic [3:0] mon;
		logic [4:0] dom;
		logic [4:0] hr;
		logic [5:0] mins;
		logic [5:0] secs;
	} reading_t;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        cfg_wr_en    = 1'b0;
	logic [15:0] cfg_wr_data  = '0;
	logic        item_valid   = 1'b0;
	logic [2:0]  kind         = '0;
	logic [6:0]  load_year    = '0;
	logic [3:0]  load_month   = '0;
	logic [4:0]  load_day     = '0;
	logic [4:0]  load_hour    = '0;
	logic [5:0]  load_minute  = '0;
	logic [5:0]  load_second  = '0;
	logic        result_ready = 1'b0;
	logic        item_ready;
	logic        result_valid;
	logic [6:0]  year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic        setting_active;
	logic [2:0]  selected_field;
	logic        blink_on;
	logic        commit_time;

	time_editor_board board;

	int send_idle_pct  = 0;   // chance per cycle that the sender holds off
	int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
	int quiet_cycles   = 0;
	int sent           = 0;
	bit editing_now    = 1'b0; // stimulus-side view of set mode

	calendar_time_set_editor_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.kind          (kind),
		.load_year     (load_year),
		.load_month    (load_month),
		.load_day      (load_day),
		.load_hour     (load_hour),
		.load_minute   (load_minute),
		.load_second   (load_second),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.setting_active(setting_active),
		.selected_field(selected_field),
		.blink_on      (blink_on),
		.commit_time   (commit_time)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random back-pressure at the current phase's stall rate
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: every handshake is sampled on the edge where it completes.
	// A result is always from an earlier transaction, so checking it first
	// and noting the new input second keeps the queue in order.
	always @(posedge clk) begin
		clock_view_t got;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				got.yr     = year;
				got.mon    = month;
				got.dom    = day;
				got.hr     = hour;
				got.mins   = minute;
				got.secs   = second;
				got.active = setting_active;
				got.sel    = selected_field;
				got.blink  = blink_on;
				got.commit = commit_time;
				board.check_view(got);
			end
			if (item_valid && item_ready)
				board.note_event(kind, load_year, load_month, load_day,
					load_hour, load_minute, load_second);
			// watchdog: any transaction or register write counts as progress
			if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_wr_en)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Field-width random content; drives every bit of every load field
	function automatic reading_t raw_reading();
		reading_t r;
		r.yr   = 7'($urandom);
		r.mon  = 4'($urandom);
		r.dom  = 5'($urandom);
		r.hr   = 5'($urandom);
		r.mins = 6'($urandom);
		r.secs = 6'($urandom);
		return r;
	endfunction

	// Mostly legal readings, a good share at the wrap points, some raw
	function automatic reading_t clock_reading();
		reading_t r;
		int       pick;
		pick = $urandom_range(99);
		if (pick < 20) begin
			r = raw_reading();
		end else if (pick < 50) begin
			r.yr = $urandom_range(1) ? ctse_pkg::YEAR_MAX : 7'($urandom_range(0, 3));
			case ($urandom_range(3))
				0:       r.mon = 4'd1;
				1:       r.mon = 4'd2;
				2:       r.mon = ctse_pkg::MONTH_MAX;
				default: r.mon = 4'($urandom_range(1, 12));
			endcase
			r.dom  = 5'($urandom_range(27, 31));
			r.hr   = $urandom_range(1) ? ctse_pkg::HOUR_MAX : 5'd0;
			r.mins = $urandom_range(1) ? ctse_pkg::MIN_SEC_MAX : 6'd0;
			r.secs = $urandom_range(1) ? ctse_pkg::MIN_SEC_MAX : 6'd0;
		end else begin
			r.yr   = 7'($urandom_range(0, 99));
			r.mon  = 4'($urandom_range(1, 12));
			r.dom  = 5'($urandom_range(1, 31));
			r.hr   = 5'($urandom_range(0, 23));
			r.mins = 6'($urandom_range(0, 59));
			r.secs = 6'($urandom_range(0, 59));
		end
		return r;
	endfunction

	// Present one transaction and hold it until accepted. Entered and left
	// on a rising edge, so valid gets one assignment per edge.
	task automatic send_event(logic [2:0] k, reading_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		item_valid  <= 1'b1;
		kind        <= k;
		load_year   <= r.yr;
		load_month  <= r.mon;
		load_day    <= r.dom;
		load_hour   <= r.hr;
		load_minute <= r.mins;
		load_second <= r.secs;
		do
			@(posedge clk);
		while (!item_ready);
		sent++;
	endtask

	// Keys and ticks carry junk on the load fields; the block must ignore it
	task automatic send_key(logic [2:0] k);
		send_event(k, raw_reading());
	endtask

	// Stop sending and wait for every pending result
	task automatic drain();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending_views.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_half_period(logic [15:0] p);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= p;
		@(posedge clk);
		board.set_half_period(p);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// One edit: enter set mode, a run of selects, key bursts, ticks and
	// ignored readings, then usually leave set mode to commit.
	task automatic edit_session();
		int       n_edits;
		int       burst;
		int       r;
		logic [2:0] dir;
		if (!editing_now) begin
			if ($urandom_range(99) < 40)
				send_event(ctse_pkg::KIND_READ, clock_reading());
			send_key(ctse_pkg::KIND_MODE);
			editing_now = 1'b1;
		end
		n_edits = $urandom_range(1, 12);
		repeat (n_edits) begin
			r = $urandom_range(99);
			if (r < 25) begin
				send_key(ctse_pkg::KIND_SELECT);
			end else if (r < 75) begin
				// long bursts now and then to wrap minutes and seconds
				burst = ($urandom_range(99) < 5) ? $urandom_range(20, 70) : $urandom_range(1, 8);
				dir   = $urandom_range(1) ? 3'(ctse_pkg::KIND_UP) : 3'(ctse_pkg::KIND_DOWN);
				repeat (burst) send_key(dir);
			end else if (r < 88) begin
				send_key(ctse_pkg::KIND_TICK);
			end else if (r < 94) begin
				send_event(ctse_pkg::KIND_READ, clock_reading());
			end else begin
				send_key(3'($urandom_range(6, 7)));
			end
		end
		// now and then the session is left open and the next one carries on
		if ($urandom_range(99) < 92) begin
			send_key(ctse_pkg::KIND_MODE);
			editing_now = 1'b0;
		end
	endtask

	// Traffic around the edits: tick runs, readings, stray keys, unused kinds
	task automatic background_traffic();
		case ($urandom_range(3))
			0:       repeat ($urandom_range(1, 20)) send_key(ctse_pkg::KIND_TICK);
			1:       send_event(ctse_pkg::KIND_READ, clock_reading());
			2:       send_key(3'($urandom_range(ctse_pkg::KIND_SELECT, ctse_pkg::KIND_DOWN)));
			default: send_key(3'($urandom_range(6, 7)));
		endcase
	endtask

	initial begin
		reading_t    ones;
		reading_t    zeros;
		reading_t    leap_day;
		logic [15:0] periods [8];
		int          target;

		board = new();

		ones     = '{7'h7f, 4'hf, 5'h1f, 5'h1f, 6'h3f, 6'h3f};
		zeros    = '{7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0};
		leap_day = '{7'd4, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, reset blink period ----
		send_key(ctse_pkg::KIND_TICK);
		send_event(ctse_pkg::KIND_READ, ones);  // out-of-range reading stored as is
		send_key(ctse_pkg::KIND_MODE);          // enter set mode on year
		send_key(ctse_pkg::KIND_UP);            // year 127 wraps; hour/min/sec/month wrap too
		send_key(ctse_pkg::KIND_DOWN);          // year 0 underflows to 99
		send_event(ctse_pkg::KIND_READ, zeros); // reading in set mode is ignored
		send_key(ctse_pkg::KIND_SELECT);
		send_key(ctse_pkg::KIND_DOWN);          // month 1 underflows to 12
		send_key(ctse_pkg::KIND_SELECT);
		send_key(ctse_pkg::KIND_UP);            // day past month limit
		send_key(ctse_pkg::KIND_MODE);          // leave set mode, commit pulse
		send_key(ctse_pkg::KIND_UP);            // ignored outside set mode
		send_key(ctse_pkg::KIND_SELECT);        // ignored outside set mode
		send_key(3'd6);                         // unused kinds
		send_key(3'd7);
		send_event(ctse_pkg::KIND_READ, leap_day);
		send_key(ctse_pkg::KIND_MODE);
		send_key(ctse_pkg::KIND_UP);            // year 5: Feb 29 no longer valid, day to 1
		repeat (5) send_key(ctse_pkg::KIND_SELECT); // walk to the second field
		send_key(ctse_pkg::KIND_UP);            // second 59 wraps to 0
		send_key(ctse_pkg::KIND_SELECT);        // selection wraps back to year
		send_key(ctse_pkg::KIND_MODE);
		drain();

		// ---- random part: period extremes and idle mixes per phase ----
		periods = '{16'd1, 16'd0, 16'd65535, 16'd2, 16'd3, 16'd7, 16'd1, 16'd500};
		periods[7] = 16'($urandom_range(4, 40));
		foreach (periods[p]) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			write_half_period(periods[p]);
			target = sent + PHASE_ITEMS;
			while (sent < target) begin
				if ($urandom_range(99) < 80)
					edit_session();
				else
					background_traffic();
			end
			// registers are only written with nothing in flight
			drain();
		end

		if (board.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
